// ===== hw/rtl/m3ri_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3ri_pkg
// Shared types and constants of the 3x3 rational inverse block.
// ----------------------------------------------------------------------------
package m3ri_pkg;

    localparam int ACC_W = 64;   // working width, arithmetic wraps here
    localparam int IDX_W = 4;
    localparam int NUM_W = 32;
    localparam int DEN_W = 48;
    localparam int DET_W = 49;
    localparam int OUT_W = 136;  // result fields packed, padded to bytes

    // multiply sequence: 18 cofactor products, then 6 determinant partials
    localparam logic [4:0] STEP_DET0 = 5'd18;
    localparam logic [4:0] STEP_LAST = 5'd23;
    localparam logic [3:0] ENTRY_LAST = 4'd8;

    // one inverse entry handed from front to back
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [ACC_W-1:0] adj;
        logic [ACC_W-1:0] det;
        logic             sing;
        logic             last;
    } t_job;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_PUSH
    } t_fstate;

    typedef enum logic [2:0] {
        B_IDLE,
        B_GCD,
        B_GWAIT,
        B_QWAIT,
        B_DWAIT,
        B_OUT
    } t_bstate;

endpackage
`default_nettype wire

// ===== hw/rtl/m3ri_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3ri_front
// Takes a matrix beat, forms the cofactors and the determinant on one shared
// multiplier, then queues one job per inverse entry (or one singular job).
// ----------------------------------------------------------------------------
module m3ri_front #(
    parameter int EW = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire  [9*EW-1:0]     i_elems,
    output logic                o_job_valid,
    input  wire                 i_job_ready,
    output m3ri_pkg::t_job      o_job
);

    localparam int PW = EW + 33;

    m3ri_pkg::t_fstate r_state, n_state;

    logic signed [EW-1:0]                r_m [9];
    logic [m3ri_pkg::ACC_W-1:0]          r_cof [9];
    logic [m3ri_pkg::ACC_W-1:0]          r_acc, r_det, r_prod;
    logic [4:0]                          r_step, r_pstep;
    logic                                r_iss, r_pv;
    logic [3:0]                          r_k;

    logic signed [EW-1:0]   w_a;
    logic signed [32:0]     w_b;
    logic signed [PW-1:0]   w_prod;
    logic [m3ri_pkg::ACC_W-1:0] w_adj;
    logic                   w_sing;

    // operand selection for the current multiply step
    always_comb begin
        w_a = r_m[0];
        w_b = 33'(r_m[0]);
        case (r_step)
            5'd0:  begin w_a = r_m[4]; w_b = 33'(r_m[8]); end
            5'd1:  begin w_a = r_m[5]; w_b = 33'(r_m[7]); end
            5'd2:  begin w_a = r_m[5]; w_b = 33'(r_m[6]); end
            5'd3:  begin w_a = r_m[3]; w_b = 33'(r_m[8]); end
            5'd4:  begin w_a = r_m[3]; w_b = 33'(r_m[7]); end
            5'd5:  begin w_a = r_m[4]; w_b = 33'(r_m[6]); end
            5'd6:  begin w_a = r_m[7]; w_b = 33'(r_m[2]); end
            5'd7:  begin w_a = r_m[8]; w_b = 33'(r_m[1]); end
            5'd8:  begin w_a = r_m[8]; w_b = 33'(r_m[0]); end
            5'd9:  begin w_a = r_m[6]; w_b = 33'(r_m[2]); end
            5'd10: begin w_a = r_m[6]; w_b = 33'(r_m[1]); end
            5'd11: begin w_a = r_m[7]; w_b = 33'(r_m[0]); end
            5'd12: begin w_a = r_m[1]; w_b = 33'(r_m[5]); end
            5'd13: begin w_a = r_m[2]; w_b = 33'(r_m[4]); end
            5'd14: begin w_a = r_m[2]; w_b = 33'(r_m[3]); end
            5'd15: begin w_a = r_m[0]; w_b = 33'(r_m[5]); end
            5'd16: begin w_a = r_m[0]; w_b = 33'(r_m[4]); end
            5'd17: begin w_a = r_m[1]; w_b = 33'(r_m[3]); end
            // determinant partials: low half unsigned, high half signed
            5'd18: begin w_a = r_m[0]; w_b = {1'b0, r_cof[0][31:0]}; end
            5'd19: begin w_a = r_m[0]; w_b = {r_cof[0][63], r_cof[0][63:32]}; end
            5'd20: begin w_a = r_m[1]; w_b = {1'b0, r_cof[1][31:0]}; end
            5'd21: begin w_a = r_m[1]; w_b = {r_cof[1][63], r_cof[1][63:32]}; end
            5'd22: begin w_a = r_m[2]; w_b = {1'b0, r_cof[2][31:0]}; end
            5'd23: begin w_a = r_m[2]; w_b = {r_cof[2][63], r_cof[2][63:32]}; end
            default: begin w_a = r_m[0]; w_b = 33'(r_m[0]); end
        endcase
    end

    assign w_prod = w_a * w_b;

    // adjugate entry k is cofactor (column, row)
    always_comb begin
        case (r_k)
            4'd0:    w_adj = r_cof[0];
            4'd1:    w_adj = r_cof[3];
            4'd2:    w_adj = r_cof[6];
            4'd3:    w_adj = r_cof[1];
            4'd4:    w_adj = r_cof[4];
            4'd5:    w_adj = r_cof[7];
            4'd6:    w_adj = r_cof[2];
            4'd7:    w_adj = r_cof[5];
            4'd8:    w_adj = r_cof[8];
            default: w_adj = r_cof[0];
        endcase
    end

    assign w_sing = (r_det == '0);

    // next state and handshakes
    always_comb begin
        n_state     = r_state;
        o_ready     = 1'b0;
        o_job_valid = 1'b0;
        case (r_state)
            m3ri_pkg::F_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) n_state = m3ri_pkg::F_MUL;
            end
            m3ri_pkg::F_MUL: begin
                if (r_pv && r_pstep == m3ri_pkg::STEP_LAST) n_state = m3ri_pkg::F_PUSH;
            end
            m3ri_pkg::F_PUSH: begin
                o_job_valid = 1'b1;
                if (i_job_ready && o_job.last) n_state = m3ri_pkg::F_IDLE;
            end
            default: n_state = m3ri_pkg::F_IDLE;
        endcase
    end

    assign o_job.idx  = w_sing ? 4'd0 : r_k;
    assign o_job.adj  = w_adj;
    assign o_job.det  = r_det;
    assign o_job.sing = w_sing;
    assign o_job.last = w_sing || (r_k == m3ri_pkg::ENTRY_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= m3ri_pkg::F_IDLE;
        else          r_state <= n_state;
    end

    // control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_pstep <= '0;
            r_iss   <= 1'b0;
            r_pv    <= 1'b0;
            r_k     <= '0;
        end else begin
            r_pv    <= r_iss;
            r_pstep <= r_step;
            if (r_state == m3ri_pkg::F_IDLE && i_valid) begin
                r_step <= '0;
                r_iss  <= 1'b1;
                r_k    <= '0;
            end else if (r_iss) begin
                if (r_step == m3ri_pkg::STEP_LAST) r_iss <= 1'b0;
                else                               r_step <= r_step + 5'd1;
            end
            if (r_state == m3ri_pkg::F_PUSH && i_job_ready) r_k <= r_k + 4'd1;
        end
    end

    // datapath: element capture, product register, accumulation
    always_ff @(posedge i_clk) begin
        if (r_state == m3ri_pkg::F_IDLE && i_valid) begin
            for (int e = 0; e < 9; e++) r_m[e] <= i_elems[e*EW +: EW];
        end
        r_prod <= {{(m3ri_pkg::ACC_W-PW){w_prod[PW-1]}}, w_prod};
        if (r_pv) begin
            if (r_pstep < m3ri_pkg::STEP_DET0) begin
                if (!r_pstep[0]) r_acc <= r_prod;
                else             r_cof[r_pstep[4:1]] <= r_acc - r_prod;
            end else begin
                r_det <= ((r_pstep == m3ri_pkg::STEP_DET0) ? '0 : r_det)
                       + (r_pstep[0] ? {r_prod[31:0], 32'd0} : r_prod);
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/m3ri_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3ri_queue
// Four-deep job queue between the front and the back.
// ----------------------------------------------------------------------------
module m3ri_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_ready,
    input  m3ri_pkg::t_job  i_job,
    output logic            o_valid,
    input  wire             i_ready,
    output m3ri_pkg::t_job  o_job
);

    m3ri_pkg::t_job r_mem [4];
    logic [1:0]     r_wp, r_rp;
    logic [2:0]     r_cnt;
    logic           w_push, w_pop;

    assign o_ready = (r_cnt != 3'd4);
    assign o_valid = (r_cnt != 3'd0);
    assign o_job   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 2'd1;
            if (w_pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'd0, w_push} - {2'd0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_job;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/m3ri_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3ri_div
// Unsigned 64-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module m3ri_div (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire  [63:0] i_dvd,
    input  wire  [63:0] i_dvs,
    output logic        o_done,
    output logic [63:0] o_quo,
    output logic [63:0] o_rem
);

    logic [63:0] r_q, r_rem, r_dvs;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [64:0] w_sh, w_diff;

    assign w_sh   = {r_rem, r_q[63]};
    assign w_diff = w_sh - {1'b0, r_dvs};
    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_rem  = r_rem;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift and trial subtract
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dvd;
            r_rem <= '0;
            r_dvs <= i_dvs;
        end else if (r_busy) begin
            if (!w_diff[64]) begin
                r_rem <= w_diff[63:0];
                r_q   <= {r_q[62:0], 1'b1};
            end else begin
                r_rem <= w_sh[63:0];
                r_q   <= {r_q[62:0], 1'b0};
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/m3ri_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3ri_back
// Reduces one adjugate entry over the determinant: Euclid gcd on the shared
// divider, then two exact divisions, into a registered result beat.
// ----------------------------------------------------------------------------
module m3ri_back (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_job_valid,
    output logic                         o_job_ready,
    input  m3ri_pkg::t_job               i_job,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [m3ri_pkg::OUT_W-1:0]   o_data,
    output logic                         o_user,
    output logic                         o_last
);

    m3ri_pkg::t_bstate r_state, n_state;

    logic [63:0] r_a, r_b, r_amag, r_dmag, r_q, r_den, r_det;
    logic [3:0]  r_idx;
    logic        r_neg, r_sing, r_last, r_ovalid;
    logic [m3ri_pkg::OUT_W-1:0] r_odata;
    logic        r_ouser, r_olast;

    logic        w_start, w_done;
    logic [63:0] w_dvd, w_dvs, w_quo, w_rem, w_amag, w_dmag, w_num;
    logic        w_load;

    assign w_amag = i_job.adj[63] ? (64'd0 - i_job.adj) : i_job.adj;
    assign w_dmag = i_job.det[63] ? (64'd0 - i_job.det) : i_job.det;
    assign w_num  = r_neg ? (64'd0 - r_q) : r_q;

    m3ri_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_dvd   (w_dvd),
        .i_dvs   (w_dvs),
        .o_done  (w_done),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        o_job_ready = 1'b0;
        w_start     = 1'b0;
        w_dvd       = r_a;
        w_dvs       = r_b;
        w_load      = 1'b0;
        case (r_state)
            m3ri_pkg::B_IDLE: begin
                o_job_ready = 1'b1;
                if (i_job_valid) begin
                    if (i_job.sing || w_amag == '0) n_state = m3ri_pkg::B_OUT;
                    else                            n_state = m3ri_pkg::B_GCD;
                end
            end
            m3ri_pkg::B_GCD: begin
                w_start = 1'b1;
                if (r_b == '0) begin
                    // gcd found in r_a
                    w_dvd   = r_amag;
                    w_dvs   = r_a;
                    n_state = m3ri_pkg::B_QWAIT;
                end else begin
                    n_state = m3ri_pkg::B_GWAIT;
                end
            end
            m3ri_pkg::B_GWAIT: begin
                if (w_done) n_state = m3ri_pkg::B_GCD;
            end
            m3ri_pkg::B_QWAIT: begin
                if (w_done) begin
                    w_start = 1'b1;
                    w_dvd   = r_dmag;
                    w_dvs   = r_a;
                    n_state = m3ri_pkg::B_DWAIT;
                end
            end
            m3ri_pkg::B_DWAIT: begin
                if (w_done) n_state = m3ri_pkg::B_OUT;
            end
            m3ri_pkg::B_OUT: begin
                if (!r_ovalid || i_ready) begin
                    w_load  = 1'b1;
                    n_state = m3ri_pkg::B_IDLE;
                end
            end
            default: n_state = m3ri_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= m3ri_pkg::B_IDLE;
        else          r_state <= n_state;
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            m3ri_pkg::B_IDLE: begin
                r_idx  <= i_job.idx;
                r_sing <= i_job.sing;
                r_last <= i_job.last;
                r_det  <= i_job.det;
                r_neg  <= i_job.adj[63] ^ i_job.det[63];
                r_amag <= w_amag;
                r_dmag <= w_dmag;
                r_a    <= w_amag;
                r_b    <= w_dmag;
                r_q    <= '0;
                r_den  <= 64'd1;
            end
            m3ri_pkg::B_GWAIT: begin
                if (w_done) begin
                    r_a <= r_b;
                    r_b <= w_rem;
                end
            end
            m3ri_pkg::B_QWAIT: begin
                if (w_done) r_q <= w_quo;
            end
            m3ri_pkg::B_DWAIT: begin
                if (w_done) r_den <= w_quo;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_odata <= {2'b00,
                        r_det[m3ri_pkg::DET_W-1:0],
                        !r_sing && (r_den == 64'd1),
                        r_den[m3ri_pkg::DEN_W-1:0],
                        w_num[m3ri_pkg::NUM_W-1:0],
                        r_idx};
            r_ouser <= r_sing;
            r_olast <= r_last;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
    assign o_user  = r_ouser;
    assign o_last  = r_olast;

endmodule
`default_nettype wire

// ===== hw/rtl/matrix3_rational_inverse.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix3_rational_inverse
// Exact rational inverse of a signed 3x3 integer matrix.
// ----------------------------------------------------------------------------
// Usage:
//  One input beat carries a whole matrix, elements row-major from the low
//  bits. For a singular matrix one result beat comes out, tuser high. Else
//  nine beats come out in row-major order, each a reduced fraction
//  adj/det with a positive denominator; tlast marks the final beat.
//  Flow: the front forms the products on its one multiplier before its
//  first job, then queues up to nine jobs. The back shares one 64-bit
//  bit-serial divider: each nonzero entry costs (Euclid steps + 2)
//  divisions, so the time a matrix takes is set by the number of Euclid
//  remainder steps. Singular matrices and zero entries need no division.
//  The front accepts the next matrix once its jobs are all queued, so it
//  overlaps the back's work. A stalled receiver holds the result register;
//  the back then waits and the queue fills, which stops the front.
//  Reset (synchronous, active low) empties the queue and idles both parts.
// ----------------------------------------------------------------------------
module matrix3_rational_inverse #(
    parameter int ELEMENT_WIDTH = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up, zero padded
    input  wire  [((9*ELEMENT_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    // entry_index, numerator, denominator, is_integer, det_value from bit 0
    output logic [m3ri_pkg::OUT_W-1:0]   m_axis_tdata,
    // singular
    output logic                         m_axis_tuser,
    output logic                         m_axis_tlast
);

    m3ri_pkg::t_job w_fjob, w_bjob;
    logic w_fvalid, w_fready, w_bvalid, w_bready;

    m3ri_front #(
        .EW (ELEMENT_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_elems     (s_axis_tdata[9*ELEMENT_WIDTH-1:0]),
        .o_job_valid (w_fvalid),
        .i_job_ready (w_fready),
        .o_job       (w_fjob)
    );

    m3ri_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fvalid),
        .o_ready (w_fready),
        .i_job   (w_fjob),
        .o_valid (w_bvalid),
        .i_ready (w_bready),
        .o_job   (w_bjob)
    );

    m3ri_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_bvalid),
        .o_job_ready (w_bready),
        .i_job       (w_bjob),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata),
        .o_user      (m_axis_tuser),
        .o_last      (m_axis_tlast)
    );

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 3x3 rational inverse: drives matrices, predicts
// each reduced fraction of the inverse and compares every result beat.
// ----------------------------------------------------------------------------
module tb;

    localparam int EW     = 16;
    localparam int IN_W   = ((9*EW+7)/8)*8;
    localparam int LIMIT  = 50000000;
    localparam int IDX_W  = m3ri_pkg::IDX_W;
    localparam int NUM_W  = m3ri_pkg::NUM_W;
    localparam int DEN_W  = m3ri_pkg::DEN_W;
    localparam int DET_W  = m3ri_pkg::DET_W;
    localparam int OUT_W  = m3ri_pkg::OUT_W;

    // field order follows the result beat, highest bits first
    typedef struct packed {
        logic [DET_W-1:0] det;
        logic             is_int;
        logic [DEN_W-1:0] den;
        logic [NUM_W-1:0] num;
        logic [IDX_W-1:0] idx;
        logic             sing;
        logic             last;
    } t_frac;

    logic             i_clk;
    logic             i_rst_n;
    logic             s_tvalid;
    wire              s_tready;
    logic [IN_W-1:0]  s_tdata;
    wire              m_tvalid;
    logic             m_tready;
    wire  [OUT_W-1:0] m_tdata;
    wire              m_tuser;
    wire              m_tlast;

    logic [IN_W-1:0]  matrix_q[$];
    t_frac            frac_q[$];
    int               src_idle_pct;
    int               snk_idle_pct;
    int               errors;
    int               cycles;
    int               n_beats;
    int               n_sing;
    bit               stim_done;
    logic             s_tready_seen;

    matrix3_rational_inverse #(.ELEMENT_WIDTH(EW)) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_tvalid),
        .s_axis_tready(s_tready),
        .s_axis_tdata (s_tdata),
        .m_axis_tvalid(m_tvalid),
        .m_axis_tready(m_tready),
        .m_axis_tdata (m_tdata),
        .m_axis_tuser (m_tuser),
        .m_axis_tlast (m_tlast)
    );

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    function automatic logic [63:0] elem(logic [IN_W-1:0] d, int k);
        return 64'(signed'(d[k*EW +: EW]));
    endfunction

    function automatic logic [63:0] magn(logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function automatic logic [63:0] euclid(logic [63:0] a, logic [63:0] b);
        logic [63:0] t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    // exact inverse as reduced fractions, queued in output order
    function automatic void predict_inverse(logic [IN_W-1:0] d);
        logic [63:0] m[3][3];
        logic [63:0] cof[3][3];
        logic [63:0] det, dmag, a, amag, g, q;
        t_frac f;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = elem(d, i*3+j);
        // cyclic indices carry the checkerboard sign
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                cof[i][j] = m[(i+1)%3][(j+1)%3] * m[(i+2)%3][(j+2)%3]
                          - m[(i+1)%3][(j+2)%3] * m[(i+2)%3][(j+1)%3];
        det = m[0][0]*cof[0][0] + m[0][1]*cof[0][1] + m[0][2]*cof[0][2];
        if (det == 0) begin
            f = '{idx: '0, num: '0, den: DEN_W'(1), is_int: 1'b0, det: '0,
                  sing: 1'b1, last: 1'b1};
            frac_q.push_back(f);
            return;
        end
        dmag = magn(det);
        for (int k = 0; k < 9; k++) begin
            a = cof[k%3][k/3];
            amag = magn(a);
            f.idx = IDX_W'(k);
            f.det = det[DET_W-1:0];
            f.sing = 1'b0;
            f.last = (k == 8);
            if (amag == 0) begin
                f.num = '0; f.den = DEN_W'(1); f.is_int = 1'b1;
            end else begin
                g = euclid(amag, dmag);
                q = amag / g;
                f.num = NUM_W'((a[63] ^ det[63]) ? -q : q);
                f.den = DEN_W'(dmag / g);
                f.is_int = (dmag / g == 1);
            end
            frac_q.push_back(f);
        end
    endfunction

    function automatic logic [IN_W-1:0] pack9(int v[9]);
        logic [IN_W-1:0] d;
        d = '0;
        for (int k = 0; k < 9; k++) d[k*EW +: EW] = EW'(v[k]);
        return d;
    endfunction

    // element with a bias toward small and extreme values
    function automatic int rnd_elem();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32767 : -32768;
            1, 2: return int'($urandom_range(0, 20)) - 10;
            3: return int'($urandom_range(0, 400)) - 200;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // driver: new beat offered at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready_seen) begin
            if (matrix_q.size() > 0 && $urandom_range(1, 100) > src_idle_pct) begin
                s_tdata  <= matrix_q.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= i_rst_n && ($urandom_range(1, 100) > snk_idle_pct);
    end

    // accept seen at the rising edge, prediction made there
    always @(posedge i_clk) begin
        s_tready_seen <= 1'b0;
        if (i_rst_n && s_tvalid && s_tready) begin
            predict_inverse(s_tdata);
            s_tready_seen <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_frac got, want;
        cycles <= cycles + 1;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = {m_tdata[IDX_W+NUM_W+DEN_W+1+DET_W-1:0], m_tuser, m_tlast};
            n_beats <= n_beats + 1;
            if (m_tuser) n_sing <= n_sing + 1;
            if (frac_q.size() == 0) begin
                $display("%0t: unexpected beat %h", $time, got);
                errors <= errors + 1;
            end else begin
                want = frac_q.pop_front();
                if (got.idx !== want.idx || got.num !== want.num ||
                    got.den !== want.den || got.is_int !== want.is_int ||
                    got.det !== want.det || got.sing !== want.sing ||
                    got.last !== want.last) begin
                    $display("%0t: expected idx=%0d num=%0d den=%0d int=%b det=%0d s=%b l=%b",
                             $time, want.idx, $signed(want.num), want.den,
                             want.is_int, $signed(want.det), want.sing, want.last);
                    $display("%0t: actual   idx=%0d num=%0d den=%0d int=%b det=%0d s=%b l=%b",
                             $time, got.idx, $signed(got.num), got.den,
                             got.is_int, $signed(got.det), got.sing, got.last);
                    errors <= errors + 1;
                end
            end
        end
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("matrix3_rational_inverse: mismatch");
            $finish;
        end
    end

    task automatic drain();
        while (matrix_q.size() != 0 || s_tvalid) @(posedge i_clk);
        while (frac_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    initial begin
        int v[9];
        i_rst_n = 1'b0; s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
        s_tready_seen = 1'b0;
        errors = 0; cycles = 0; n_beats = 0; n_sing = 0;
        src_idle_pct = 29; snk_idle_pct = 66;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;

        // directed: identity, zero, extremes, singular rows, mixed signs
        v = '{1, 0, 0, 0, 1, 0, 0, 0, 1};               matrix_q.push_back(pack9(v));
        v = '{0, 0, 0, 0, 0, 0, 0, 0, 0};               matrix_q.push_back(pack9(v));
        v = '{1, 2, 3, 2, 4, 6, 7, 8, 9};               matrix_q.push_back(pack9(v));
        v = '{2, 0, 0, 0, 3, 0, 0, 0, 4};               matrix_q.push_back(pack9(v));
        v = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768}; matrix_q.push_back(pack9(v));
        v = '{32767, 0, 0, 0, 32767, 0, 0, 0, 32767};   matrix_q.push_back(pack9(v));
        v = '{-32768, 32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768};
        matrix_q.push_back(pack9(v));
        v = '{32767, -32768, 0, -32768, 32767, -32768, 0, -32768, 32767};
        matrix_q.push_back(pack9(v));
        v = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};      matrix_q.push_back(pack9(v));
        v = '{0, 1, 0, 0, 0, 1, 1, 0, 0};               matrix_q.push_back(pack9(v));
        v = '{2, -1, 0, -1, 2, -1, 0, -1, 2};           matrix_q.push_back(pack9(v));
        v = '{6, 4, 2, 3, 9, 12, 5, 10, 15};            matrix_q.push_back(pack9(v));
        matrix_q.push_back('1);
        matrix_q.push_back(IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin src_idle_pct = 66; snk_idle_pct = 29; end
            if (phase == 2) begin src_idle_pct = 0;  snk_idle_pct = 0;  end
            for (int n = 0; n < 66; n++) begin
                for (int k = 0; k < 9; k++) v[k] = rnd_elem();
                // some rank-deficient matrices: one row a multiple of another
                if ($urandom_range(0, 9) == 0)
                    for (int k = 0; k < 3; k++) v[6+k] = v[k] * int'($urandom_range(0, 2));
                matrix_q.push_back(pack9(v));
            end
            drain();
        end

        $display("%0d result beats checked, %0d singular, over three handshake regimes",
                 n_beats, n_sing);
        if (errors == 0) begin
            $display("matrix3_rational_inverse: match");
        end else begin
            $display("matrix3_rational_inverse: mismatch");
        end
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/m3ri_pkg.sv
hw/rtl/m3ri_front.sv
hw/rtl/m3ri_queue.sv
hw/rtl/m3ri_div.sv
hw/rtl/m3ri_back.sv
hw/rtl/matrix3_rational_inverse.sv
verif/tb.sv
